/* rtl/ldrs_pkg.sv */
// ----------------------------------------------------------------------------
// ldrs_pkg: shared types, constants and helpers for the lattice dimer stepper
// Coordinate and size types, the lattice step tables and the wrapped adder
// that the coordinate updates of moves and places use.
// ----------------------------------------------------------------------------
package ldrs_pkg;

    localparam int COORD_W   = 10;
    localparam int SIZE_W    = 11;
    localparam int MAX_SIDE  = 1024;
    localparam int NUM_COORD = 6;

    // Slots of the coordinate arrays.
    localparam int IDX_CX = 0;
    localparam int IDX_CY = 1;
    localparam int IDX_AX = 2;
    localparam int IDX_AY = 3;
    localparam int IDX_BX = 4;
    localparam int IDX_BY = 5;

    // The remainder unit takes one dividend bit per cycle.
    localparam int RED_STEPS = COORD_W;
    localparam int CNT_W     = $clog2(RED_STEPS + 1);

    localparam logic ACT_MOVE  = 1'b0;
    localparam logic ACT_PLACE = 1'b1;

    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic [SIZE_W-1:0]        t_len;
    typedef logic signed [2:0]        t_step;
    typedef logic signed [SIZE_W-1:0] t_diff;
    typedef logic signed [SIZE_W+1:0] t_wide;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef struct packed {
        t_coord center_x;
        t_coord center_y;
        t_coord end_one_x;
        t_coord end_one_y;
        t_coord end_two_x;
        t_coord end_two_y;
        logic   rejected;
    } t_res;

    localparam t_len SIZE_RESET = t_len'(256);
    localparam t_len LEN_MIN    = t_len'(4);
    localparam t_len LEN_MAX    = t_len'(MAX_SIDE) & ~t_len'(1);

    // Effective side: low bit cleared, then clamped to the legal range.
    function automatic t_len eff_len(input t_len size);
        t_len s;
        s = {size[SIZE_W-1:1], 1'b0};
        if (s < LEN_MIN) begin
            s = LEN_MIN;
        end else if (s > LEN_MAX) begin
            s = LEN_MAX;
        end
        return s;
    endfunction

    localparam t_coord TWO_X_RESET = t_coord'(eff_len(SIZE_RESET) - t_len'(2));

    function automatic t_step step_dx(input logic [2:0] dir);
        t_step d;
        case (dir)
            3'd0:    d = -3'sd2;
            3'd1:    d = 3'sd2;
            3'd2:    d = 3'sd1;
            3'd3:    d = -3'sd1;
            3'd4:    d = 3'sd1;
            3'd5:    d = -3'sd1;
            default: d = 3'sd0;
        endcase
        return d;
    endfunction

    function automatic t_step step_dy(input logic [2:0] dir);
        t_step d;
        case (dir)
            3'd2:    d = 3'sd1;
            3'd3:    d = 3'sd1;
            3'd4:    d = -3'sd1;
            3'd5:    d = -3'sd1;
            default: d = 3'sd0;
        endcase
        return d;
    endfunction

    // (v + d) mod len, for v below len and d in -2..2.
    function automatic t_coord wrap_add(input t_coord v, input t_step d, input t_len len);
        t_wide t;
        t_wide l;
        l = t_wide'({2'b00, len});
        t = t_wide'({3'b000, v}) + t_wide'(d);
        if (t < 0) begin
            t = t + l;
        end else if (t >= l) begin
            t = t - l;
        end
        return t[COORD_W-1:0];
    endfunction

    // Sign of a difference, kept when the ends are near neighbors and
    // flipped when the pair straddles the wrap edge.
    function automatic t_step sign_sel(input t_diff dd, input logic near);
        t_step s;
        if (dd > 0) begin
            s = 3'sd1;
        end else if (dd < 0) begin
            s = -3'sd1;
        end else begin
            s = 3'sd0;
        end
        return near ? s : -s;
    endfunction

endpackage

/* rtl/ldrs_if.sv */
// ----------------------------------------------------------------------------
// ldrs_if: item and result channels of the lattice dimer stepper
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ldrs_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [2:0]           direction;
    logic                 turn;
    ldrs_pkg::t_coord     place_x;
    ldrs_pkg::t_coord     place_y_draw;

    modport source (
        output valid, action, direction, turn, place_x, place_y_draw,
        input  ready
    );
    modport sink (
        input  valid, action, direction, turn, place_x, place_y_draw,
        output ready
    );
endinterface

interface ldrs_out_if;
    logic                 valid;
    logic                 ready;
    ldrs_pkg::t_coord     center_x;
    ldrs_pkg::t_coord     center_y;
    ldrs_pkg::t_coord     end_one_x;
    ldrs_pkg::t_coord     end_one_y;
    ldrs_pkg::t_coord     end_two_x;
    ldrs_pkg::t_coord     end_two_y;
    logic                 rejected;

    modport source (
        output valid, center_x, center_y, end_one_x, end_one_y,
               end_two_x, end_two_y, rejected,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, end_one_x, end_one_y,
               end_two_x, end_two_y, rejected,
        output ready
    );
endinterface

/* rtl/lattice_dimer_random_step_top.sv */
// ----------------------------------------------------------------------------
// lattice_dimer_random_step_top: one dimer on a periodic triangular lattice
// Place and move steps for a three-site particle, one item per clock while ready.
// ----------------------------------------------------------------------------
// The block takes one item beat per clock while ready is high and returns
// one result beat per item: the state update is a single pass
// of wrapped small adds and sign decisions between the position registers and
// the result register. A two-entry output buffer (result register plus skid
// register) lets the input keep flowing for one beat while the sink stalls.
// Writing the lattice size drops ready while a bit-serial remainder
// unit reduces all six stored coordinates modulo the new side, one dividend
// bit per cycle, so that a move after a shrink starts from wrapped positions.
// Reset loads a size of 256 with the remainder unit idle.
module lattice_dimer_random_step_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ldrs_in_if.sink          i_item,
    ldrs_out_if.source       o_res,
    input  logic             i_cfg_we,
    input  ldrs_pkg::t_len   i_cfg_wdata
);
    import ldrs_pkg::*;

    // Configuration and the effective side derived from it.
    t_len   r_size;
    t_len   len;

    // Positions as last reported, and the same positions reduced modulo the
    // side. They differ only between a size write and the next update.
    t_coord r_raw [NUM_COORD];
    t_coord r_red [NUM_COORD];

    // Remainder unit: shifting dividends and the step counter.
    t_coord r_src [NUM_COORD];
    t_cnt   r_cnt;
    t_coord n_rem [NUM_COORD];
    logic   busy;

    // Output buffer.
    t_res   r_out;
    logic   r_out_valid;
    t_res   r_skid;
    logic   r_skid_valid;
    logic   out_fire;

    // Item datapath.
    logic   accept;
    logic   update;
    t_coord n_pos [NUM_COORD];
    t_res   n_res;
    t_step  dx;
    t_step  dy;
    t_step  rot;
    t_step  sx;
    t_step  sy;
    t_coord sh [NUM_COORD];
    t_diff  ddx;
    t_diff  ddy;
    logic   near_x;
    logic   near_y;
    logic   place_bad;
    t_len   py_sum;
    t_coord place_cy;

    assign len      = eff_len(r_size);
    assign busy     = (r_cnt != '0);
    assign out_fire = r_out_valid && o_res.ready;

    // A new beat may enter unless the skid register is full or the
    // coordinates are being reduced after a size write.
    assign i_item.ready = !r_skid_valid && !busy;
    assign accept       = i_item.valid && i_item.ready;

    // One restoring-remainder step per coordinate per cycle.
    always_comb begin
        for (int k = 0; k < NUM_COORD; k++) begin
            t_len sh_rem;
            sh_rem = {r_red[k], r_src[k][COORD_W-1]};
            if (sh_rem >= len) begin
                sh_rem = sh_rem - len;
            end
            n_rem[k] = sh_rem[COORD_W-1:0];
        end
    end

    // Step offsets and the shifted positions of a move.
    assign dx  = step_dx(i_item.direction);
    assign dy  = step_dy(i_item.direction);
    assign rot = i_item.turn ? 3'sd1 : -3'sd1;

    always_comb begin
        for (int k = 0; k < NUM_COORD; k++) begin
            sh[k] = wrap_add(r_red[k], ((k % 2) == 0) ? dx : dy, len);
        end
    end

    assign ddx    = t_diff'({1'b0, sh[IDX_AX]}) - t_diff'({1'b0, sh[IDX_BX]});
    assign ddy    = t_diff'({1'b0, sh[IDX_AY]}) - t_diff'({1'b0, sh[IDX_BY]});
    assign near_x = (ddx == t_diff'(2)) || (ddx == t_diff'(4))
                 || (ddx == -t_diff'(2)) || (ddx == -t_diff'(4));
    assign near_y = (ddy == t_diff'(2)) || (ddy == -t_diff'(2));
    assign sx     = sign_sel(ddx, near_x);
    assign sy     = sign_sel(ddy, near_y);

    // Place: the draw is doubled and takes the parity of x; since the draw
    // is below the side, one conditional subtract wraps it.
    assign place_bad = ({1'b0, i_item.place_x} >= len) || ({1'b0, i_item.place_y_draw} >= len);
    assign py_sum    = {i_item.place_y_draw, i_item.place_x[0]};

    always_comb begin
        t_len y_wrapped;
        y_wrapped = (py_sum >= len) ? (py_sum - len) : py_sum;
        place_cy  = y_wrapped[COORD_W-1:0];
    end

    always_comb begin
        for (int k = 0; k < NUM_COORD; k++) begin
            n_pos[k] = r_raw[k];
        end
        update = 1'b0;
        if (i_item.action == ACT_PLACE) begin
            if (!place_bad) begin
                update       = 1'b1;
                n_pos[IDX_CX] = i_item.place_x;
                n_pos[IDX_CY] = place_cy;
                n_pos[IDX_AX] = wrap_add(i_item.place_x, dx, len);
                n_pos[IDX_AY] = wrap_add(place_cy, dy, len);
                n_pos[IDX_BX] = wrap_add(i_item.place_x, -dx, len);
                n_pos[IDX_BY] = wrap_add(place_cy, -dy, len);
            end
        end else begin
            update = 1'b1;
            for (int k = 0; k < NUM_COORD; k++) begin
                n_pos[k] = sh[k];
            end
            if (sh[IDX_AY] == sh[IDX_BY]) begin
                // Horizontal dimer: the ends move into the neighboring rows.
                n_pos[IDX_AX] = wrap_add(sh[IDX_AX], -sx, len);
                n_pos[IDX_AY] = wrap_add(sh[IDX_AY], rot, len);
                n_pos[IDX_BX] = wrap_add(sh[IDX_BX], sx, len);
                n_pos[IDX_BY] = wrap_add(sh[IDX_BY], -rot, len);
            end else if (rot < 0) begin
                // Diagonal dimer turning into the other diagonal.
                n_pos[IDX_AX] = wrap_add(sh[IDX_AX], -(sx + sx), len);
                n_pos[IDX_BX] = wrap_add(sh[IDX_BX], sx + sx, len);
            end else begin
                // Diagonal dimer turning into a horizontal one.
                n_pos[IDX_AX] = wrap_add(sh[IDX_AX], sx, len);
                n_pos[IDX_AY] = wrap_add(sh[IDX_AY], -sy, len);
                n_pos[IDX_BX] = wrap_add(sh[IDX_BX], -sx, len);
                n_pos[IDX_BY] = wrap_add(sh[IDX_BY], sy, len);
            end
        end

        n_res.center_x  = n_pos[IDX_CX];
        n_res.center_y  = n_pos[IDX_CY];
        n_res.end_one_x = n_pos[IDX_AX];
        n_res.end_one_y = n_pos[IDX_AY];
        n_res.end_two_x = n_pos[IDX_BX];
        n_res.end_two_y = n_pos[IDX_BY];
        n_res.rejected  = !update;
    end

    // Control state, configuration and positions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size        <= SIZE_RESET;
            r_cnt         <= '0;
            r_raw[IDX_CX] <= '0;
            r_raw[IDX_CY] <= '0;
            r_raw[IDX_AX] <= t_coord'(2);
            r_raw[IDX_AY] <= '0;
            r_raw[IDX_BX] <= TWO_X_RESET;
            r_raw[IDX_BY] <= '0;
            r_red[IDX_CX] <= '0;
            r_red[IDX_CY] <= '0;
            r_red[IDX_AX] <= t_coord'(2);
            r_red[IDX_AY] <= '0;
            r_red[IDX_BX] <= TWO_X_RESET;
            r_red[IDX_BY] <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
            r_cnt  <= t_cnt'(RED_STEPS);
            for (int k = 0; k < NUM_COORD; k++) begin
                r_red[k] <= '0;
            end
        end else if (busy) begin
            r_cnt <= r_cnt - t_cnt'(1);
            for (int k = 0; k < NUM_COORD; k++) begin
                r_red[k] <= n_rem[k];
            end
        end else if (accept && update) begin
            for (int k = 0; k < NUM_COORD; k++) begin
                r_raw[k] <= n_pos[k];
                r_red[k] <= n_pos[k];
            end
        end
    end

    // Dividend shift registers of the remainder unit.
    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            for (int k = 0; k < NUM_COORD; k++) begin
                r_src[k] <= r_raw[k];
            end
        end else if (busy) begin
            for (int k = 0; k < NUM_COORD; k++) begin
                r_src[k] <= {r_src[k][COORD_W-2:0], 1'b0};
            end
        end
    end

    // Output buffer valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_res;
            end
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.center_x  = r_out.center_x;
    assign o_res.center_y  = r_out.center_y;
    assign o_res.end_one_x = r_out.end_one_x;
    assign o_res.end_one_y = r_out.end_one_y;
    assign o_res.end_two_x = r_out.end_two_x;
    assign o_res.end_two_y = r_out.end_two_y;
    assign o_res.rejected  = r_out.rejected;

endmodule

/* rtl/ldrs_checker.sv */
// ----------------------------------------------------------------------------
// ldrs_checker: port-level checks for the lattice dimer stepper
// Watches the top level's channels and configuration port over time.
// ----------------------------------------------------------------------------
module ldrs_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  ldrs_pkg::t_res          i_out_res,
    input  logic                    i_cfg_we
);
    import ldrs_pkg::*;

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Every accepted item beat shows a result beat on the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted item produced no result beat");

    // A size write starts the coordinate reduction, which blocks input.
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_in_ready)
        else $error("input ready right after a size write");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_res))
        else $error("stalled result beat changed");

endmodule

bind lattice_dimer_random_step_top ldrs_checker u_ldrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_res   ({o_res.center_x, o_res.center_y, o_res.end_one_x, o_res.end_one_y,
                   o_res.end_two_x, o_res.end_two_y, o_res.rejected}),
    .i_cfg_we    (i_cfg_we)
);
